[hw/rtl/ttw_pkg.sv]
// Shared types, constants and helpers for the text terminal writer.
package ttw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int IDX_W  = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic                 scrolled;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic fill_step;
    logic fill_clear;
    logic read_issue;
    logic read_capture;
    logic put_exec;
    logic out_load;
  } ttw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_read;
    logic scroll_next;
    logic fill_done;
  } ttw_status_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] attr);
    return {attr, ch};
  endfunction

  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, SPACE_CHAR};

endpackage

[hw/rtl/ttw_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module ttw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ttw_ctrl.sv]
// Controller state machine of the text terminal writer.
module ttw_ctrl
  import ttw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ttw_status_t status,
  output ttw_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_READ      = 7'b0000100,
    ST_READ_DATA = 7'b0001000,
    ST_PUT       = 7'b0010000,
    ST_SCROLL    = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.fill_step  = 1'b1;
        cmd.fill_clear = 1'b1;
        if (status.fill_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = status.in_is_read ? ST_READ : ST_PUT;
        end
      end
      ST_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        cmd.read_capture = 1'b1;
        state_next       = ST_DONE;
      end
      ST_PUT: begin
        cmd.put_exec = 1'b1;
        state_next   = status.scroll_next ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("result overwritten while waiting");

  // A loaded result is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not offered");

endmodule

[hw/rtl/ttw_datapath.sv]
// Datapath of the text terminal writer: cursor, row pointer, screen store, result register.
module ttw_datapath
  import ttw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ATTR_W-1:0] cfg_data,
  input  in_item_t          in_item,
  input  ttw_cmd_t          cmd,
  output ttw_status_t       status,
  output out_item_t         out_item
);

  in_item_t          item;
  logic [ATTR_W-1:0] attr;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] row_base;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] top_base;
  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] fill_end;
  logic [CELL_W-1:0] result_cell;
  logic              scrolled;

  logic              is_newline;
  logic              col_last;
  logic              row_last;
  logic              line_adv;
  logic              idx_in_range;
  logic [SUM_W-1:0]  put_sum;
  logic [SUM_W-1:0]  read_sum;
  logic [ADDR_W-1:0] put_phys;
  logic [ADDR_W-1:0] read_phys;
  logic [CELL_W-1:0] fill_cell;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  assign is_newline   = (item.char_code == NEWLINE_CHAR);
  assign col_last     = (col == COL_W'(COLUMNS - 1));
  assign row_last     = (row == ROW_W'(ROWS - 1));
  assign line_adv     = is_newline || col_last;
  assign idx_in_range = (32'(item.cell_index) < 32'(CELL_COUNT));

  // The store is a ring of rows; top_base is the physical start of screen row zero.
  assign put_sum   = SUM_W'(top_base) + SUM_W'(row_base) + SUM_W'(col);
  assign put_phys  = (put_sum >= SUM_W'(CELL_COUNT)) ?
                     ADDR_W'(put_sum - SUM_W'(CELL_COUNT)) : ADDR_W'(put_sum);
  assign read_sum  = SUM_W'(top_base) + SUM_W'(ADDR_W'(item.cell_index));
  assign read_phys = (read_sum >= SUM_W'(CELL_COUNT)) ?
                     ADDR_W'(read_sum - SUM_W'(CELL_COUNT)) : ADDR_W'(read_sum);

  assign fill_cell = cmd.fill_clear ? RESET_CELL : make_cell(SPACE_CHAR, attr);

  assign ram_we    = cmd.fill_step || (cmd.put_exec && !is_newline);
  assign ram_waddr = cmd.fill_step ? fill_addr : put_phys;
  assign ram_wdata = cmd.fill_step ? fill_cell : make_cell(item.char_code, attr);

  assign status.in_is_read  = (in_item.action == ACT_READ);
  assign status.scroll_next = line_adv && row_last;
  assign status.fill_done   = (fill_addr == fill_end);

  ttw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read_issue && idx_in_range),
    .raddr (read_phys),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= RESET_ATTR;
      row       <= '0;
      row_base  <= '0;
      col       <= '0;
      top_base  <= '0;
      fill_addr <= '0;
      fill_end  <= ADDR_W'(CELL_COUNT - 1);
      scrolled  <= 1'b0;
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      if (cmd.load_item) begin
        scrolled <= 1'b0;
      end
      if (cmd.fill_step) begin
        fill_addr <= fill_addr + ADDR_W'(1);
      end
      if (cmd.put_exec) begin
        if (line_adv) begin
          col <= '0;
          if (row_last) begin
            // Old top row becomes the new bottom row and is blanked.
            scrolled  <= 1'b1;
            fill_addr <= top_base;
            fill_end  <= top_base + ADDR_W'(COLUMNS - 1);
            top_base  <= (top_base == ADDR_W'(CELL_COUNT - COLUMNS)) ?
                         '0 : top_base + ADDR_W'(COLUMNS);
          end else begin
            row      <= row + ROW_W'(1);
            row_base <= row_base + ADDR_W'(COLUMNS);
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
    if (cmd.read_capture) begin
      result_cell <= idx_in_range ? ram_rdata : '0;
    end
    if (cmd.put_exec) begin
      result_cell <= is_newline ? '0 : make_cell(item.char_code, attr);
    end
    if (cmd.out_load) begin
      out_item.cell_value <= result_cell;
      out_item.cursor_row <= ROW_OUT_W'(row);
      out_item.cursor_col <= COL_OUT_W'(col);
      out_item.scrolled   <= scrolled;
    end
  end

  // The cursor stays on the screen.
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(row) < ROWS) && (32'(col) < COLUMNS))
    else $error("cursor off screen");

  // A fill never runs past its last cell.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> (fill_addr <= fill_end))
    else $error("fill past its end");

endmodule

[hw/rtl/text_terminal_writer.sv]
// Top level of the text terminal writer: controller plus datapath.
//
// A character-cell terminal of ROWS by COLUMNS 16-bit cells (character in the
// low byte, attribute in the high byte) with a cursor. A put item (action 0)
// writes its character with the current attribute at the cursor and advances
// it; newline (code 10) goes to column 0 of the next row without writing, and
// leaving the last row scrolls the screen up one row, blanking the bottom row
// with spaces in the current attribute. A read item (action 1) returns one
// cell by its screen index; an index past the screen returns 0. Every item
// gives exactly one result carrying the cursor after the item. The screen is
// kept as a ring of rows, so a scroll moves the top-row pointer and rewrites a
// single row instead of copying the screen. Items are handled one at a time:
// a read passes through the read, read-data and done states, a put through the
// put and done states, and a put that scrolls also through a scroll state that
// makes one store write per cell of the blanked row. After reset a clearing
// pass writes spaces with attribute 0x07 to all ROWS * COLUMNS cells, one
// cell per cycle, during which in_ready stays low; attribute writes are taken
// during that pass as at any other time. The next item can be accepted while a
// finished result is still waiting on out_ready.
// The attribute must only be written while no item is in flight.
module text_terminal_writer
  import ttw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ATTR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  ttw_cmd_t    cmd;
  ttw_status_t status;

  ttw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ttw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule
